>>> hw/rtl/tbeg_pkg.sv
package tbeg_pkg;

   localparam int LOG_TABLE_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF     = 24;

   // operand widths of the shared shift-add multiplier
   localparam int MUL_A_BITS = 34;
   localparam int MUL_B_BITS = 32;

   localparam logic [15:0] ONE_Q15 = 16'd32768;

   typedef enum logic [2:0] {
      STG_IDLE    = 3'd0,
      STG_ON_ATK  = 3'd1,
      STG_ON_DEC  = 3'd2,
      STG_SUSTAIN = 3'd3,
      STG_OFF_ATK = 3'd4,
      STG_OFF_DEC = 3'd5
   } stage_type;

   typedef enum logic [2:0] {
      CSR_HEIGHTS    = 3'd0,
      CSR_EXPONENTS  = 3'd1,
      CSR_ON_ATK_LEN = 3'd2,
      CSR_ON_DEC_LEN = 3'd3,
      CSR_OFF_ATK_LEN = 3'd4,
      CSR_OFF_DEC_LEN = 3'd5,
      CSR_SLEW       = 3'd6
   } csr_index_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bitv;
      v    = value;
      r    = '0;
      bitv = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // q1.30 value of 2^(-1/2^k), evaluated at elaboration only
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'd1 << 30;
      if (k >= 1) r = isqrt64(64'd1 << 59);
      for (int j = 2; j <= 12; j++) begin
         if (j <= k) r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

>>> hw/rtl/tbeg_serial_mul.sv
module tbeg_serial_mul #(
   parameter int A_BITS = tbeg_pkg::MUL_A_BITS,
   parameter int B_BITS = tbeg_pkg::MUL_B_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_BITS-1:0]          a,
   input  logic [B_BITS-1:0]          b,
   output logic                       done,
   output logic [A_BITS+B_BITS-1:0]   prod
);
   localparam int CNT_W = $clog2(B_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [A_BITS-1:0]        a_ff, a_in;
   logic [A_BITS+B_BITS-1:0] prod_ff, prod_in;
   logic [A_BITS:0]          step_sum;

   // one multiplier bit per cycle, partial sum shifts down into the low half
   assign step_sum = {1'b0, prod_ff[A_BITS+B_BITS-1:B_BITS]}
                   + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(B_BITS);
         a_in    = a;
         prod_in = {{A_BITS{1'b0}}, b};
      end else if (busy_ff) begin
         prod_in = {step_sum, prod_ff[B_BITS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

>>> hw/rtl/two_bump_envelope_generator.sv
// Two-bump envelope generator, one gate bit in and one smoothed level out per sample tick.
// req_valid/req_ready carry the gate bit of one tick; rsp_valid/rsp_ready carry the
// resulting level (Q1.15) and the stage the step ends in.
// csr_valid/csr_ready write one configuration register by index; csr_ready is always high,
// and registers are to be written only while no transaction is in flight.
// Every product goes through one shift-add multiplier; entry into a timed stage with a nonzero
// length runs a restoring divider for the phase step.
// A timed stage tick runs at most the phase product, squaring for the log, the exponent
// product, root products for the exp, the scaling and two smoothing products; idle and
// sustain ticks run only the two smoothing products.
// One transaction is worked at a time; req_ready is high only while the sequencer is idle.
// The finished result sits in an output register, so the next transaction is taken
// while the receiver stalls; the sequencer only waits at its end when that register
// is still full.
// Synchronous reset returns stage, step count, held and smoothed levels to zero and loads register defaults.
module two_bump_envelope_generator #(
   parameter int LOG_TABLE_BITS = tbeg_pkg::LOG_TABLE_BITS_DEF,
   parameter int COUNT_BITS     = tbeg_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_gate_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_level,
   output logic [2:0]  rsp_stage_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import tbeg_pkg::*;

   localparam int CW   = COUNT_BITS + 1;
   localparam int IDXW = $clog2(LOG_TABLE_BITS + 1);
   localparam int NLW  = LOG_TABLE_BITS + 5;
   localparam int MA   = MUL_A_BITS;
   localparam int MB   = MUL_B_BITS;
   localparam int MP   = MA + MB;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_DIV   = 13'b0000000000010,
      S_EVAL  = 13'b0000000000100,
      S_PHASE = 13'b0000000001000,
      S_NORM  = 13'b0000000010000,
      S_SQR   = 13'b0000000100000,
      S_TMUL  = 13'b0000001000000,
      S_ROOT  = 13'b0000010000000,
      S_FINAL = 13'b0000100000000,
      S_SCALE = 13'b0001000000000,
      S_SMA   = 13'b0010000000000,
      S_SMB   = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } seq_state_type;

   // configuration
   logic [47:0]           heights_ff;
   logic [63:0]           exponents_ff;
   logic [COUNT_BITS-1:0] on_atk_len_ff, on_dec_len_ff, off_atk_len_ff, off_dec_len_ff;
   logic [15:0]           slew_ff;

   // sequencer and envelope state
   seq_state_type         state_ff, state_in;
   stage_type             stage_ff, stage_in;
   logic                  prev_gate_ff, prev_gate_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           scale_ff, scale_in;
   logic [15:0]           held_ff, held_in;
   logic [15:0]           smooth_ff, smooth_in;
   logic [15:0]           target_ff, target_in;
   logic [31:0]           acc_ff, acc_in;
   logic                  mul_wait_ff, mul_wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_level_ff, rsp_level_in;
   stage_type             rsp_stage_ff, rsp_stage_in;

   // divider
   logic [CW-1:0]         div_rem_ff, div_rem_in;
   logic [31:0]           div_q_ff, div_q_in;
   logic [4:0]            div_cnt_ff, div_cnt_in;
   logic [COUNT_BITS-1:0] div_len_ff, div_len_in;
   logic                  div_ret_eval_ff, div_ret_eval_in;

   // power datapath
   logic [30:0]           m_ff, m_in;
   logic [4:0]            sh_ff, sh_in;
   logic [LOG_TABLE_BITS-1:0] frac_ff, frac_in;
   logic [IDXW-1:0]       k_ff, k_in;
   logic [4:0]            ti_ff, ti_in;
   logic [LOG_TABLE_BITS-1:0] tf_ff, tf_in;
   logic [30:0]           r_ff, r_in;
   logic [IDXW-1:0]       i_ff, i_in;
   logic [16:0]           p_ff, p_in;

   // multiplier port
   logic                  mul_start;
   logic [MA-1:0]         mul_a;
   logic [MB-1:0]         mul_b;
   logic                  mul_done;
   logic [MP-1:0]         mul_prod;

   logic [30:0]           root_tab [1:LOG_TABLE_BITS];

   for (genvar g = 1; g <= LOG_TABLE_BITS; g++) begin : g_root
      assign root_tab[g] = root_q30(g);
   end

   // clamped heights
   logic [15:0] ob_raw, sus, offb, ob, hang;
   logic [16:0] sus_ob_sum, held_offb_sum;
   assign ob_raw = (heights_ff[15:0] > ONE_Q15) ? ONE_Q15 : heights_ff[15:0];
   assign sus    = (heights_ff[31:16] > ONE_Q15) ? ONE_Q15 : heights_ff[31:16];
   assign offb   = (heights_ff[47:32] > ONE_Q15) ? ONE_Q15 : heights_ff[47:32];
   assign sus_ob_sum    = {1'b0, sus} + {1'b0, ob_raw};
   assign ob            = (sus_ob_sum > 17'(ONE_Q15)) ? ONE_Q15 - sus : ob_raw;
   assign held_offb_sum = {1'b0, held_ff} + {1'b0, offb};
   assign hang          = (held_offb_sum > 17'(ONE_Q15)) ? ONE_Q15 - offb : held_ff;

   // per-stage exponent and height
   logic [15:0] exp_sel, h_sel;
   logic        is_attack;
   always_comb begin
      exp_sel   = '0;
      h_sel     = '0;
      is_attack = 1'b0;
      case (stage_ff)
         STG_ON_ATK: begin
            exp_sel   = exponents_ff[15:0];
            h_sel     = sus + ob;
            is_attack = 1'b1;
         end
         STG_ON_DEC: begin
            exp_sel = exponents_ff[31:16];
            h_sel   = ob;
         end
         STG_OFF_ATK: begin
            exp_sel   = exponents_ff[47:32];
            h_sel     = offb;
            is_attack = 1'b1;
         end
         STG_OFF_DEC: begin
            exp_sel = exponents_ff[63:48];
            h_sel   = hang + offb;
         end
         default: begin
            exp_sel = '0;
         end
      endcase
   end

   // datapath terms
   logic [CW-1:0]  div_shifted;
   logic           div_ge;
   logic [15:0]    phase_x;
   logic [16:0]    pow_base;
   logic [31:0]    sq;
   logic [NLW-1:0] neglog;
   logic [33:0]    tsum;
   logic [33:0]    tint;
   logic [62:0]    rsum;
   logic [31:0]    fsum;
   logic [33:0]    scale_sum;
   logic [33:0]    smooth_sum;
   logic [15:0]    sc;

   assign div_shifted = {div_rem_ff[COUNT_BITS-1:0], 1'b1};
   assign div_ge      = div_shifted >= {1'b0, div_len_ff};
   assign phase_x     = (|mul_prod[MP-1:32]) ? 16'hFFFF : mul_prod[31:16];
   assign pow_base    = is_attack ? {1'b0, phase_x} : 17'd65536 - {1'b0, phase_x};
   assign sq          = mul_prod[61:30];
   assign neglog      = (NLW'(sh_ff - 5'd14) << LOG_TABLE_BITS) - NLW'(frac_ff);
   assign tsum        = mul_prod[33:0] + 34'd2048;
   assign tint        = tsum >> (12 + LOG_TABLE_BITS);
   assign rsum        = mul_prod[62:0] + 63'd536870912;
   assign fsum        = {1'b0, r_ff} + (32'd1 << (5'd13 + ti_ff));
   assign scale_sum   = {1'b0, mul_prod[32:0]} + 34'd32768;
   assign sc          = scale_sum[31:16];
   assign smooth_sum  = {2'b0, acc_ff} + {1'b0, mul_prod[32:0]} + 34'd32768;

   // multiplier operand selection
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_PHASE: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(count_ff);
            mul_b     = scale_ff;
         end
         S_SQR: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(m_ff);
            mul_b     = MB'(m_ff);
         end
         S_TMUL: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(neglog);
            mul_b     = MB'(exp_sel);
         end
         S_ROOT: begin
            mul_start = !mul_wait_ff && tf_ff[LOG_TABLE_BITS-1];
            mul_a     = MA'(r_ff);
            mul_b     = MB'(root_tab[i_ff]);
         end
         S_SCALE: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(h_sel);
            mul_b     = MB'(p_ff);
         end
         S_SMA: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(slew_ff);
            mul_b     = MB'(smooth_ff);
         end
         S_SMB: begin
            mul_start = !mul_wait_ff;
            mul_a     = MA'(17'd65536 - {1'b0, slew_ff});
            mul_b     = MB'(target_ff);
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   tbeg_serial_mul #(
      .A_BITS (MA),
      .B_BITS (MB)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in        = state_ff;
      stage_in        = stage_ff;
      prev_gate_in    = prev_gate_ff;
      count_in        = count_ff;
      scale_in        = scale_ff;
      held_in         = held_ff;
      smooth_in       = smooth_ff;
      target_in       = target_ff;
      acc_in          = acc_ff;
      mul_wait_in     = mul_wait_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_stage_in    = rsp_stage_ff;
      div_rem_in      = div_rem_ff;
      div_q_in        = div_q_ff;
      div_cnt_in      = div_cnt_ff;
      div_len_in      = div_len_ff;
      div_ret_eval_in = div_ret_eval_ff;
      m_in            = m_ff;
      sh_in           = sh_ff;
      frac_in         = frac_ff;
      k_in            = k_ff;
      ti_in           = ti_ff;
      tf_in           = tf_ff;
      r_in            = r_ff;
      i_in            = i_ff;
      p_in            = p_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (mul_start) mul_wait_in = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               prev_gate_in    = req_gate_high;
               div_rem_in      = '0;
               div_q_in        = '0;
               div_cnt_in      = '0;
               div_ret_eval_in = 1'b1;
               state_in        = S_EVAL;
               if (!prev_gate_ff && req_gate_high) begin
                  stage_in   = STG_ON_ATK;
                  count_in   = '0;
                  div_len_in = on_atk_len_ff;
                  if (on_atk_len_ff != '0) state_in = S_DIV;
               end else if (prev_gate_ff && !req_gate_high) begin
                  stage_in   = STG_OFF_ATK;
                  count_in   = '0;
                  div_len_in = off_atk_len_ff;
                  if (off_atk_len_ff != '0) state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_ge) begin
               div_rem_in = div_shifted - {1'b0, div_len_ff};
            end else begin
               div_rem_in = div_shifted;
            end
            div_q_in   = {div_q_ff[30:0], div_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'd31) begin
               scale_in = {div_q_ff[30:0], div_ge};
               state_in = div_ret_eval_ff ? S_EVAL : S_SMA;
            end
         end
         S_EVAL: begin
            // stage end: move on with a zero target this tick; idle targets zero, sustain its own level
            div_rem_in      = '0;
            div_q_in        = '0;
            div_cnt_in      = '0;
            div_ret_eval_in = 1'b0;
            state_in        = S_PHASE;
            case (stage_ff)
               STG_IDLE: begin
                  target_in = '0;
                  state_in  = S_SMA;
               end
               STG_ON_ATK: begin
                  if (count_ff >= {1'b0, on_atk_len_ff}) begin
                     target_in  = '0;
                     stage_in   = STG_ON_DEC;
                     count_in   = '0;
                     div_len_in = on_dec_len_ff;
                     state_in   = (on_dec_len_ff != '0) ? S_DIV : S_SMA;
                  end
               end
               STG_ON_DEC: begin
                  if (count_ff >= {1'b0, on_dec_len_ff}) begin
                     target_in = '0;
                     stage_in  = STG_SUSTAIN;
                     count_in  = '0;
                     state_in  = S_SMA;
                  end
               end
               STG_SUSTAIN: begin
                  target_in = sus;
                  held_in   = sus;
                  state_in  = S_SMA;
               end
               STG_OFF_ATK: begin
                  if (count_ff >= {1'b0, off_atk_len_ff}) begin
                     target_in  = '0;
                     stage_in   = STG_OFF_DEC;
                     count_in   = '0;
                     div_len_in = off_dec_len_ff;
                     state_in   = (off_dec_len_ff != '0) ? S_DIV : S_SMA;
                  end
               end
               STG_OFF_DEC: begin
                  if (count_ff >= {1'b0, off_dec_len_ff}) begin
                     target_in = '0;
                     stage_in  = STG_IDLE;
                     count_in  = '0;
                     state_in  = S_SMA;
                  end
               end
               default: begin
                  target_in = '0;
                  stage_in  = STG_IDLE;
                  count_in  = '0;
                  state_in  = S_SMA;
               end
            endcase
         end
         S_PHASE: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               if (pow_base == '0) begin
                  p_in     = (exp_sel == '0) ? 17'd65536 : 17'd0;
                  state_in = S_SCALE;
               end else begin
                  m_in     = 31'(pow_base);
                  sh_in    = '0;
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            // shift the base up until it sits in [1, 2) as q1.30
            if (m_ff[30]) begin
               k_in     = '0;
               frac_in  = '0;
               state_in = S_SQR;
            end else begin
               m_in  = {m_ff[29:0], 1'b0};
               sh_in = sh_ff + 1'b1;
            end
         end
         S_SQR: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               m_in        = sq[31] ? sq[31:1] : sq[30:0];
               frac_in     = {frac_ff[LOG_TABLE_BITS-2:0], sq[31]};
               k_in        = k_ff + 1'b1;
               if (k_ff == IDXW'(LOG_TABLE_BITS - 1)) state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               if (tint > 34'd16) begin
                  p_in     = '0;
                  state_in = S_SCALE;
               end else begin
                  ti_in    = tint[4:0];
                  tf_in    = tsum[12+LOG_TABLE_BITS-1:12];
                  r_in     = 31'd1 << 30;
                  i_in     = IDXW'(1);
                  state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            // walk the fraction bits msb first, one root product per set bit
            if (!mul_wait_ff && !tf_ff[LOG_TABLE_BITS-1]) begin
               tf_in = {tf_ff[LOG_TABLE_BITS-2:0], 1'b0};
               i_in  = i_ff + 1'b1;
               if (i_ff == IDXW'(LOG_TABLE_BITS)) state_in = S_FINAL;
            end else if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               r_in        = rsum[60:30];
               tf_in       = {tf_ff[LOG_TABLE_BITS-2:0], 1'b0};
               i_in        = i_ff + 1'b1;
               if (i_ff == IDXW'(LOG_TABLE_BITS)) state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            p_in     = 17'(fsum >> (5'd14 + ti_ff));
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               state_in    = S_SMA;
               case (stage_ff)
                  STG_ON_ATK: begin
                     target_in = sc;
                     held_in   = sc;
                  end
                  STG_ON_DEC: begin
                     target_in = sus + sc;
                     held_in   = sus + sc;
                  end
                  STG_OFF_ATK: begin
                     target_in = hang + sc;
                  end
                  STG_OFF_DEC: begin
                     target_in = sc;
                  end
                  default: begin
                     target_in = '0;
                  end
               endcase
            end
         end
         S_SMA: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               acc_in      = mul_prod[31:0];
               state_in    = S_SMB;
            end
         end
         S_SMB: begin
            if (mul_wait_ff && mul_done) begin
               mul_wait_in = 1'b0;
               smooth_in   = smooth_sum[31:16];
               if (count_ff != {CW{1'b1}}) count_in = count_ff + 1'b1;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = smooth_ff;
               rsp_stage_in = stage_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         stage_ff       <= STG_IDLE;
         prev_gate_ff   <= 1'b0;
         count_ff       <= '0;
         scale_ff       <= '0;
         held_ff        <= '0;
         smooth_ff      <= '0;
         mul_wait_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         heights_ff     <= 48'd7036230189056;
         exponents_ff   <= 64'd4611756387708438528;
         on_atk_len_ff  <= COUNT_BITS'(1200);
         on_dec_len_ff  <= COUNT_BITS'(2400);
         off_atk_len_ff <= COUNT_BITS'(2400);
         off_dec_len_ff <= COUNT_BITS'(12000);
         slew_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         prev_gate_ff <= prev_gate_in;
         count_ff     <= count_in;
         scale_ff     <= scale_in;
         held_ff      <= held_in;
         smooth_ff    <= smooth_in;
         mul_wait_ff  <= mul_wait_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_HEIGHTS:     heights_ff     <= csr_wdata[47:0];
               CSR_EXPONENTS:   exponents_ff   <= csr_wdata;
               CSR_ON_ATK_LEN:  on_atk_len_ff  <= csr_wdata[COUNT_BITS-1:0];
               CSR_ON_DEC_LEN:  on_dec_len_ff  <= csr_wdata[COUNT_BITS-1:0];
               CSR_OFF_ATK_LEN: off_atk_len_ff <= csr_wdata[COUNT_BITS-1:0];
               CSR_OFF_DEC_LEN: off_dec_len_ff <= csr_wdata[COUNT_BITS-1:0];
               CSR_SLEW:        slew_ff        <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff       <= target_in;
      acc_ff          <= acc_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_stage_ff    <= rsp_stage_in;
      div_rem_ff      <= div_rem_in;
      div_q_ff        <= div_q_in;
      div_cnt_ff      <= div_cnt_in;
      div_len_ff      <= div_len_in;
      div_ret_eval_ff <= div_ret_eval_in;
      m_ff            <= m_in;
      sh_ff           <= sh_in;
      frac_ff         <= frac_in;
      k_ff            <= k_in;
      ti_ff           <= ti_in;
      tf_ff           <= tf_in;
      r_ff            <= r_in;
      i_ff            <= i_in;
      p_ff            <= p_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_stage_now = rsp_stage_ff;

endmodule
